>>> hw/rtl/tlptq_pkg.sv
`default_nettype none
package tlptq_pkg;
	localparam int MaxTickets = 64;
	localparam int AddrW = $clog2(MaxTickets);
	localparam int CntW = $clog2(MaxTickets + 1);

	typedef enum logic [1:0] {
		KIND_REGISTER = 2'd0,
		KIND_REPRIO   = 2'd1,
		KIND_SERVE    = 2'd2,
		KIND_LOOKUP   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_BADLEVEL = 3'd3,
		ST_EMPTY    = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	localparam logic [1:0] LevelLow = 2'd1;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] ticket_id;
		logic [1:0]         new_level;
		logic [31:0]        now_time;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] out_id;
		logic [1:0]         out_level;
		logic [31:0]        out_time;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] id;
		logic [1:0]         level;
		logic [31:0]        stamp;
		logic [31:0]        order;
	} entry_t;
endpackage
`default_nettype wire

>>> hw/rtl/tlptq_req_if.sv
`default_nettype none
interface tlptq_req_if;
	import tlptq_pkg::*;
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/tlptq_rsp_if.sv
`default_nettype none
interface tlptq_rsp_if;
	import tlptq_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/three_level_priority_ticket_queue.sv
`default_nettype none
// Holds up to 64 tickets in one entry memory with a single synchronous read port. Every
// request walks all entries once, one address per cycle, to find a matching id, the lowest
// free slot or the oldest ticket of the highest level, then writes back at most one entry;
// a request passes through the scan and write states before its response is registered,
// and the next request is taken once the response register is free.
module three_level_priority_ticket_queue (
	input wire clk,
	input wire arst_n,
	tlptq_req_if.sink req,
	tlptq_rsp_if.source rsp
);
	import tlptq_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE} state_t;

	entry_t mem [MaxTickets];
	entry_t rd_data_q;
	logic [MaxTickets-1:0] valid_q;
	state_t state_q;
	req_t cmd_q;
	logic [31:0] order_cnt_q;
	logic [CntW-1:0] rd_cnt_q;
	logic [AddrW-1:0] cmp_addr_q;
	logic cmp_live_q;
	logic found_q, free_q, best_q;
	logic [AddrW-1:0] found_addr_q, free_addr_q, best_addr_q;
	logic [1:0] found_level_q, best_level_q;
	logic [31:0] best_age_q, best_time_q, found_time_q;
	logic signed [31:0] best_id_q;
	logic out_valid_q;
	rsp_t out_q;
	rsp_t resp_d;
	logic we;
	logic [AddrW-1:0] waddr;
	entry_t wdata;
	logic [31:0] age;
	logic hit, better;

	assign req.ready = (state_q == S_IDLE) && !out_valid_q;
	assign rsp.valid = out_valid_q;
	assign rsp.payload = out_q;

	assign age = order_cnt_q - rd_data_q.order;
	assign hit = valid_q[cmp_addr_q] && rd_data_q.id == cmd_q.ticket_id;
	assign better = !best_q || rd_data_q.level > best_level_q ||
		(rd_data_q.level == best_level_q && age > best_age_q);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[rd_cnt_q[AddrW-1:0]];
	end

	always_comb begin
		we = 1'b0;
		waddr = free_addr_q;
		wdata.id = cmd_q.ticket_id;
		wdata.level = LevelLow;
		wdata.stamp = cmd_q.now_time;
		wdata.order = order_cnt_q;
		if (state_q == S_WRITE) begin
			if (cmd_q.kind == KIND_REGISTER) begin
				we = !found_q && free_q;
			end else if (cmd_q.kind == KIND_REPRIO) begin
				we = found_q && cmd_q.new_level != 2'd0 && cmd_q.new_level != found_level_q;
				waddr = found_addr_q;
				wdata.level = cmd_q.new_level;
			end
		end
	end

	always_comb begin
		resp_d = '0;
		resp_d.status = ST_OK;
		case (cmd_q.kind)
			KIND_REGISTER: begin
				if (found_q) begin
					resp_d.status = ST_DUP;
				end else if (!free_q) begin
					resp_d.status = ST_FULL;
				end else begin
					resp_d.out_id = cmd_q.ticket_id;
					resp_d.out_level = LevelLow;
					resp_d.out_time = cmd_q.now_time;
				end
			end
			KIND_REPRIO: begin
				if (!found_q) begin
					resp_d.status = ST_NOTFOUND;
				end else if (cmd_q.new_level == 2'd0 || cmd_q.new_level == found_level_q) begin
					resp_d.status = ST_BADLEVEL;
				end else begin
					resp_d.out_id = cmd_q.ticket_id;
					resp_d.out_level = cmd_q.new_level;
					resp_d.out_time = cmd_q.now_time;
				end
			end
			KIND_SERVE: begin
				if (!best_q) begin
					resp_d.status = ST_EMPTY;
				end else begin
					resp_d.out_id = best_id_q;
					resp_d.out_level = best_level_q;
					resp_d.out_time = best_time_q;
				end
			end
			default: begin
				if (!found_q) begin
					resp_d.status = ST_NOTFOUND;
				end else begin
					resp_d.out_id = cmd_q.ticket_id;
					resp_d.out_level = found_level_q;
					resp_d.out_time = found_time_q;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			order_cnt_q <= '0;
			out_valid_q <= 1'b0;
			rd_cnt_q <= '0;
			cmp_live_q <= 1'b0;
			cmp_addr_q <= '0;
			found_q <= 1'b0;
			free_q <= 1'b0;
			best_q <= 1'b0;
			cmd_q <= '0;
			out_q <= '0;
			found_addr_q <= '0;
			free_addr_q <= '0;
			best_addr_q <= '0;
			found_level_q <= '0;
			best_level_q <= '0;
			best_age_q <= '0;
			best_time_q <= '0;
			found_time_q <= '0;
			best_id_q <= '0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						cmd_q <= req.payload;
						rd_cnt_q <= '0;
						cmp_live_q <= 1'b0;
						found_q <= 1'b0;
						free_q <= 1'b0;
						best_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_cnt_q < CntW'(MaxTickets)) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					cmp_live_q <= rd_cnt_q < CntW'(MaxTickets);
					cmp_addr_q <= rd_cnt_q[AddrW-1:0];
					if (cmp_live_q) begin
						if (hit && !found_q) begin
							found_q <= 1'b1;
							found_addr_q <= cmp_addr_q;
							found_level_q <= rd_data_q.level;
							found_time_q <= rd_data_q.stamp;
						end
						if (!valid_q[cmp_addr_q] && !free_q) begin
							free_q <= 1'b1;
							free_addr_q <= cmp_addr_q;
						end
						if (valid_q[cmp_addr_q] && better) begin
							best_q <= 1'b1;
							best_addr_q <= cmp_addr_q;
							best_level_q <= rd_data_q.level;
							best_age_q <= age;
							best_time_q <= rd_data_q.stamp;
							best_id_q <= rd_data_q.id;
						end
					end
					if (!cmp_live_q && rd_cnt_q == CntW'(MaxTickets)) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					out_valid_q <= 1'b1;
					out_q <= resp_d;
					state_q <= S_IDLE;
					if (we) begin
						order_cnt_q <= order_cnt_q + 1'b1;
					end
					if (cmd_q.kind == KIND_REGISTER && we) begin
						valid_q[free_addr_q] <= 1'b1;
					end
					if (cmd_q.kind == KIND_SERVE && best_q) begin
						valid_q[best_addr_q] <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
